// ===== src/fbrm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the frame and bit rate meter.
// Depends on nothing; imported by every module of the block.
package fbrm_pkg;

  // Payload field widths.
  localparam int TIME_W  = 63;
  localparam int BYTES_W = 24;
  localparam int IV_W    = 32;
  localparam int FR_W    = 32;
  localparam int BR_W    = 40;
  localparam int HIST_W  = 7;
  localparam int IN_W    = ((TIME_W + BYTES_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMING_SOURCE     = 2'd0,
    REG_HISTORY_LENGTH    = 2'd1,
    REG_MAX_GAP           = 2'd2,
    REG_COUNTER_FREQUENCY = 2'd3
  } cfg_reg_e;

  localparam logic [HIST_W-1:0] HIST_LEN_RST = 7'd32;
  localparam logic [31:0]       MAX_GAP_RST  = 32'd50000000;
  localparam logic [31:0]       CNT_FREQ_RST = 32'd10000000;

  localparam int DEFAULT_MAX_HISTORY = 64;

  // Arithmetic constants.
  localparam int          UPS_W         = 24;
  localparam int          Q8_W          = 32;
  localparam int          MUL_K_W       = 32;
  localparam logic [31:0] UNITS_PER_SEC = 32'd10000000;
  localparam logic [31:0] Q8_UNITS      = 32'd2560000000;
  localparam int          KB_DIVISOR    = 1000;
  localparam int          KB_W          = 23;

  // Shared bit-serial divider.
  localparam int DIV_W     = 88;
  localparam int DVS_W     = 64;
  localparam int DIV_CNT_W = 7;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;  // left aligned: top nbits are the value
    logic [DVS_W-1:0]     divisor;
    logic [DIV_CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/fbrm_div.sv =====
`timescale 1ns / 1ps
// Restoring divider that retires one quotient bit per cycle.
// Depends on fbrm_pkg for the request and response structs.
module fbrm_div import fbrm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_W-1:0]     quo_q;
  logic [DVS_W-1:0]     rem_q;
  logic [DVS_W-1:0]     dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] rem_sub;
  logic           ge;

  assign trial   = {rem_q, quo_q[DIV_W-1]};
  assign ge      = trial >= {1'b0, dvs_q};
  assign rem_sub = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        quo_q  <= req_i.dividend;
        rem_q  <= '0;
        dvs_q  <= req_i.divisor;
        cnt_q  <= req_i.nbits;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        // Dividend bits leave at the top while quotient bits enter at the bottom.
        rem_q <= ge ? rem_sub[DVS_W-1:0] : trial[DVS_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], ge};
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp_o.done     = done_q;
    rsp_o.quotient = quo_q;
  end

endmodule

// ===== src/frame_and_bit_rate_meter.sv =====
`timescale 1ns / 1ps
// Frame and bit rate meter: one rate beat per frame event after the first; restart and
// first-frame beats give no beat. Counter mode adds tick conversions of the interval and
// the span, each a shift-add multiply and a pass of the one-bit-per-cycle divider.
// One event at a time: the input is ready again in the cycle after the rate beat is loaded.
// Reset is asynchronous, active low; it clears window, config and output, not the window rings.
module frame_and_bit_rate_meter import fbrm_pkg::*; #(
  parameter int  MAX_HISTORY = DEFAULT_MAX_HISTORY,
  localparam int CNT_W       = $clog2(MAX_HISTORY + 1),
  localparam int OUT_W       = ((FR_W + BR_W + CNT_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_W-1:0]       s_axis_tdata_i,   // frame_time, frame_bytes
  input  logic [0:0]            s_axis_tuser_i,   // restart
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_W-1:0]      m_axis_tdata_o,   // frame_rate_q8, bit_rate_q8, window_fill
  output logic [0:0]            m_axis_tuser_o,   // bit_rate_valid
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IDX_W  = $clog2(MAX_HISTORY);
  localparam int SUM_W  = IV_W + IDX_W;
  localparam int LIM_W  = ((CNT_W > HIST_W) ? CNT_W : HIST_W) + 1;
  localparam int ENT_W  = IV_W + BYTES_W;
  localparam int CONV_N = TIME_W + UPS_W;
  localparam int BR_N   = KB_W + 3 + Q8_W;
  localparam int MCNT_W = $clog2(MUL_K_W);

  typedef enum logic [4:0] {
    ST_IDLE, ST_IV_MUL, ST_IV_DIV, ST_CHECK, ST_POP_RD, ST_POP, ST_PUSH,
    ST_FIRST_RD, ST_FIRST, ST_MEAN, ST_FRATE, ST_KB, ST_SPAN_MUL, ST_SPAN_DIV,
    ST_BR_SETUP, ST_BR_MUL, ST_BR_DIV, ST_OUT
  } state_e;

  state_e state_q;

  // Configuration.
  logic              ts_q;
  logic [HIST_W-1:0] hl_q;
  logic [31:0]       gap_q;
  logic [31:0]       freq_q;

  // Window state.
  logic              seen_q;
  logic [TIME_W-1:0] prev_q;
  logic [IDX_W-1:0]  head_q;
  logic [CNT_W-1:0]  count_q;
  logic [SUM_W-1:0]  isum_q;
  logic [31:0]       bsum_q;

  // Per event working registers.
  logic [TIME_W-1:0]  t_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [DIV_W-1:0]   cand_q;
  logic [TIME_W-1:0]  span_q;
  logic [KB_W-1:0]    kb_q;
  logic [FR_W-1:0]    fr_q;
  logic [BR_W-1:0]    br_q;
  logic               brv_q;

  // Shift-add multiplier by a constant, one constant bit per cycle.
  logic [DIV_W-1:0]   mul_acc_q;
  logic [TIME_W-1:0]  mul_a_q;
  logic [MUL_K_W-1:0] mul_k_q;
  logic [MCNT_W-1:0]  mul_cnt_q;
  logic [DIV_W-1:0]   mul_next;

  // Divider request registers.
  logic                 div_start_q;
  logic [DIV_W-1:0]     div_dvd_q;
  logic [DVS_W-1:0]     div_dvs_q;
  logic [DIV_CNT_W-1:0] div_n_q;
  div_req_t             div_req;
  div_rsp_t             div_rsp;
  logic                 div_go;

  // Output register.
  logic             m_valid_q;
  logic [OUT_W-1:0] m_data_q;
  logic             m_user_q;
  logic             out_load;

  // Window memories.
  logic [ENT_W-1:0]  ent_mem [MAX_HISTORY];
  logic [TIME_W-1:0] tim_mem [MAX_HISTORY];
  logic [ENT_W-1:0]  ent_rd_q;
  logic [TIME_W-1:0] tim_rd_q;
  logic              mem_we;

  // Combinational helpers.
  logic               in_accept;
  logic [TIME_W-1:0]  in_time;
  logic [BYTES_W-1:0] in_bytes;
  logic               in_pos;
  logic [TIME_W-1:0]  in_d;
  logic [LIM_W-1:0]   hl_ext;
  logic [LIM_W-1:0]   max_ext;
  logic [LIM_W-1:0]   lim;
  logic [LIM_W-1:0]   cnt_inc;
  logic               need_pop;
  logic               skip_push;
  logic               cand_ok;
  logic [CNT_W:0]     idx_sum;
  logic [CNT_W:0]     idx_wrap;
  logic [IDX_W-1:0]   push_idx;
  logic [IDX_W-1:0]   head_inc;
  logic [DIV_W-1:0]   quo;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign in_time         = s_axis_tdata_i[TIME_W-1:0];
  assign in_bytes        = s_axis_tdata_i[TIME_W +: BYTES_W];
  assign in_pos          = in_time > prev_q;
  assign in_d            = in_time - prev_q;

  assign hl_ext    = LIM_W'(hl_q);
  assign max_ext   = LIM_W'(MAX_HISTORY);
  assign lim       = (hl_ext > max_ext) ? max_ext : hl_ext;
  assign cnt_inc   = LIM_W'(count_q) + LIM_W'(1);
  assign need_pop  = (count_q != '0) && (cnt_inc > lim);
  assign skip_push = (count_q == '0) && (lim == '0);
  assign cand_ok   = (cand_q != '0) && (cand_q < DIV_W'(gap_q));

  assign idx_sum  = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
  assign idx_wrap = (idx_sum >= (CNT_W+1)'(MAX_HISTORY)) ?
                    idx_sum - (CNT_W+1)'(MAX_HISTORY) : idx_sum;
  assign push_idx = idx_wrap[IDX_W-1:0];
  assign head_inc = (head_q == IDX_W'(MAX_HISTORY - 1)) ? '0 : head_q + IDX_W'(1);

  assign mul_next = {mul_acc_q[DIV_W-2:0], 1'b0} +
                    (mul_k_q[MUL_K_W-1] ? DIV_W'(mul_a_q) : '0);

  assign mem_we   = (state_q == ST_PUSH);
  assign quo      = div_rsp.quotient;
  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready_i);

  // A division starts in the cycle after its operands are loaded.
  always_comb begin
    unique case (state_q)
      ST_IV_MUL, ST_SPAN_MUL, ST_BR_MUL: div_go = (mul_cnt_q == '0);
      ST_FIRST:                          div_go = 1'b1;
      ST_MEAN, ST_FRATE:                 div_go = div_rsp.done;
      default:                           div_go = 1'b0;
    endcase
  end

  always_comb begin
    div_req.start    = div_start_q;
    div_req.dividend = div_dvd_q;
    div_req.divisor  = div_dvs_q;
    div_req.nbits    = div_n_q;
  end

  fbrm_div u_fbrm_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ent_mem[push_idx] <= {bytes_q, cand_q[IV_W-1:0]};
      tim_mem[push_idx] <= t_q;
    end
    ent_rd_q <= ent_mem[head_q];
    tim_rd_q <= tim_mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ts_q        <= 1'b0;
      hl_q        <= HIST_LEN_RST;
      gap_q       <= MAX_GAP_RST;
      freq_q      <= CNT_FREQ_RST;
      seen_q      <= 1'b0;
      prev_q      <= '0;
      head_q      <= '0;
      count_q     <= '0;
      isum_q      <= '0;
      bsum_q      <= '0;
      t_q         <= '0;
      bytes_q     <= '0;
      cand_q      <= '0;
      span_q      <= '0;
      kb_q        <= '0;
      fr_q        <= '0;
      br_q        <= '0;
      brv_q       <= 1'b0;
      mul_acc_q   <= '0;
      mul_a_q     <= '0;
      mul_k_q     <= '0;
      mul_cnt_q   <= '0;
      div_start_q <= 1'b0;
      div_dvd_q   <= '0;
      div_dvs_q   <= '0;
      div_n_q     <= '0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
      m_user_q    <= 1'b0;
    end else begin
      div_start_q <= div_go;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_TIMING_SOURCE:     ts_q   <= cfg_data_i[0];
          REG_HISTORY_LENGTH:    hl_q   <= cfg_data_i[HIST_W-1:0];
          REG_MAX_GAP:           gap_q  <= cfg_data_i;
          REG_COUNTER_FREQUENCY: freq_q <= cfg_data_i;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (s_axis_tuser_i[0]) begin
              seen_q  <= 1'b0;
              prev_q  <= '0;
              head_q  <= '0;
              count_q <= '0;
              isum_q  <= '0;
              bsum_q  <= '0;
            end else if (!seen_q) begin
              seen_q  <= 1'b1;
              prev_q  <= in_time;
              head_q  <= '0;
              count_q <= '0;
              isum_q  <= '0;
              bsum_q  <= '0;
            end else begin
              t_q     <= in_time;
              bytes_q <= in_bytes;
              if (ts_q && in_pos) begin
                mul_acc_q <= '0;
                mul_a_q   <= in_d;
                mul_k_q   <= UNITS_PER_SEC;
                mul_cnt_q <= MCNT_W'(MUL_K_W - 1);
                state_q   <= ST_IV_MUL;
              end else begin
                cand_q  <= in_pos ? DIV_W'(in_d) : '0;
                state_q <= ST_CHECK;
              end
            end
          end
        end

        ST_IV_MUL: begin
          mul_acc_q <= mul_next;
          mul_k_q   <= mul_k_q << 1;
          mul_cnt_q <= mul_cnt_q - MCNT_W'(1);
          if (mul_cnt_q == '0) begin
            div_dvd_q <= mul_next << (DIV_W - CONV_N);
            div_dvs_q <= DVS_W'(freq_q);
            div_n_q   <= DIV_CNT_W'(CONV_N);
            state_q   <= ST_IV_DIV;
          end
        end

        ST_IV_DIV: begin
          if (div_rsp.done) begin
            cand_q  <= quo;
            state_q <= ST_CHECK;
          end
        end

        ST_CHECK: begin
          prev_q <= t_q;
          fr_q   <= '0;
          br_q   <= '0;
          brv_q  <= 1'b0;
          if (!cand_ok) begin
            head_q  <= '0;
            count_q <= '0;
            isum_q  <= '0;
            bsum_q  <= '0;
            state_q <= ST_OUT;
          end else if (skip_push) begin
            state_q <= ST_OUT;
          end else if (need_pop) begin
            state_q <= ST_POP_RD;
          end else begin
            state_q <= ST_PUSH;
          end
        end

        // The read register samples the oldest entry during this cycle.
        ST_POP_RD: state_q <= ST_POP;

        ST_POP: begin
          isum_q  <= isum_q - SUM_W'(ent_rd_q[IV_W-1:0]);
          bsum_q  <= bsum_q - 32'(ent_rd_q[IV_W +: BYTES_W]);
          head_q  <= head_inc;
          count_q <= count_q - CNT_W'(1);
          state_q <= ST_PUSH;
        end

        ST_PUSH: begin
          isum_q  <= isum_q + SUM_W'(cand_q[IV_W-1:0]);
          bsum_q  <= bsum_q + 32'(bytes_q);
          count_q <= count_q + CNT_W'(1);
          state_q <= ST_FIRST_RD;
        end

        ST_FIRST_RD: state_q <= ST_FIRST;

        ST_FIRST: begin
          // The newest timestamp is the one just pushed.
          span_q    <= (t_q > tim_rd_q) ? t_q - tim_rd_q : '0;
          div_dvd_q <= DIV_W'(isum_q) << (DIV_W - SUM_W);
          div_dvs_q <= DVS_W'(count_q);
          div_n_q   <= DIV_CNT_W'(SUM_W);
          state_q   <= ST_MEAN;
        end

        ST_MEAN: begin
          if (div_rsp.done) begin
            div_dvd_q <= DIV_W'(Q8_UNITS) << (DIV_W - Q8_W);
            div_dvs_q <= quo[DVS_W-1:0];
            div_n_q   <= DIV_CNT_W'(Q8_W);
            state_q   <= ST_FRATE;
          end
        end

        ST_FRATE: begin
          if (div_rsp.done) begin
            fr_q      <= (div_dvs_q == '0) ? '0 : quo[FR_W-1:0];
            div_dvd_q <= DIV_W'(bsum_q) << (DIV_W - 32);
            div_dvs_q <= DVS_W'(KB_DIVISOR);
            div_n_q   <= DIV_CNT_W'(32);
            state_q   <= ST_KB;
          end
        end

        ST_KB: begin
          if (div_rsp.done) begin
            kb_q <= quo[KB_W-1:0];
            if (ts_q && (span_q != '0)) begin
              mul_acc_q <= '0;
              mul_a_q   <= span_q;
              mul_k_q   <= UNITS_PER_SEC;
              mul_cnt_q <= MCNT_W'(MUL_K_W - 1);
              state_q   <= ST_SPAN_MUL;
            end else begin
              state_q <= ST_BR_SETUP;
            end
          end
        end

        ST_SPAN_MUL: begin
          mul_acc_q <= mul_next;
          mul_k_q   <= mul_k_q << 1;
          mul_cnt_q <= mul_cnt_q - MCNT_W'(1);
          if (mul_cnt_q == '0) begin
            div_dvd_q <= mul_next << (DIV_W - CONV_N);
            div_dvs_q <= DVS_W'(freq_q);
            div_n_q   <= DIV_CNT_W'(CONV_N);
            state_q   <= ST_SPAN_DIV;
          end
        end

        ST_SPAN_DIV: begin
          if (div_rsp.done) begin
            // Converted spans saturate at 2^62; any such span gives a zero bit rate.
            span_q  <= (|quo[DIV_W-1:TIME_W-1]) ? (TIME_W'(1) << (TIME_W - 1)) :
                       TIME_W'(quo[TIME_W-2:0]);
            state_q <= ST_BR_SETUP;
          end
        end

        ST_BR_SETUP: begin
          if (span_q == '0) begin
            state_q <= ST_OUT;
          end else begin
            mul_acc_q <= '0;
            mul_a_q   <= TIME_W'({kb_q, 3'b000});
            mul_k_q   <= Q8_UNITS;
            mul_cnt_q <= MCNT_W'(MUL_K_W - 1);
            state_q   <= ST_BR_MUL;
          end
        end

        ST_BR_MUL: begin
          mul_acc_q <= mul_next;
          mul_k_q   <= mul_k_q << 1;
          mul_cnt_q <= mul_cnt_q - MCNT_W'(1);
          if (mul_cnt_q == '0) begin
            div_dvd_q <= mul_next << (DIV_W - BR_N);
            div_dvs_q <= DVS_W'(span_q);
            div_n_q   <= DIV_CNT_W'(BR_N);
            state_q   <= ST_BR_DIV;
          end
        end

        ST_BR_DIV: begin
          if (div_rsp.done) begin
            br_q    <= (|quo[DIV_W-1:BR_W]) ? '1 : quo[BR_W-1:0];
            brv_q   <= 1'b1;
            state_q <= ST_OUT;
          end
        end

        ST_OUT: begin
          if (out_load) begin
            m_data_q <= OUT_W'({count_q, br_q, fr_q});
            m_user_q <= brv_q;
            state_q  <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o   = m_valid_q;
  assign m_axis_tdata_o    = m_data_q;
  assign m_axis_tuser_o[0] = m_user_q;

endmodule

// ===== src/fbrm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the result stream of the frame and bit rate meter.
// Depends on fbrm_pkg; bound to frame_and_bit_rate_meter at the end of this file.
module fbrm_checker import fbrm_pkg::*; #(
  parameter int  MAX_HISTORY = DEFAULT_MAX_HISTORY,
  localparam int CNT_W       = $clog2(MAX_HISTORY + 1),
  localparam int OUT_W       = ((FR_W + BR_W + CNT_W + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             m_axis_tvalid_i,
  input logic             m_axis_tready_i,
  input logic [OUT_W-1:0] m_axis_tdata_i,   // frame_rate_q8, bit_rate_q8, window_fill
  input logic [0:0]       m_axis_tuser_i    // bit_rate_valid
);

  logic [FR_W-1:0]  fr;
  logic [BR_W-1:0]  br;
  logic [CNT_W-1:0] fill;

  assign fr   = m_axis_tdata_i[FR_W-1:0];
  assign br   = m_axis_tdata_i[FR_W +: BR_W];
  assign fill = m_axis_tdata_i[FR_W + BR_W +: CNT_W];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("result beat changed while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tuser_i[0] |-> br == '0)
    else $error("bit rate nonzero while flagged invalid");

  a_empty_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && (fill == '0) |-> (fr == '0) && !m_axis_tuser_i[0])
    else $error("rates reported for an empty window");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> 32'(fill) <= 32'(MAX_HISTORY))
    else $error("window fill above its depth");

endmodule

bind frame_and_bit_rate_meter fbrm_checker #(
  .MAX_HISTORY (MAX_HISTORY)
) u_fbrm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of frame_and_bit_rate_meter: a rate predictor follows every frame beat
// and each rate beat is compared field by field. Depends on fbrm_pkg and the meter RTL only.
module testbench;
  import fbrm_pkg::*;

  localparam int OUT_W         = ((FR_W + BR_W + HIST_W + 7) / 8) * 8;
  localparam int SETTLE_CYCLES = 1000;
  localparam int RING_DEPTH    = DEFAULT_MAX_HISTORY;
  localparam int HOLD_CYCLES   = 4000;
  localparam int DUE_DEPTH     = 16;

  localparam logic [63:0]        UNITS     = 64'(UNITS_PER_SEC);
  localparam logic [63:0]        Q8_SCALE  = 64'(Q8_UNITS);
  localparam logic [63:0]        CONV_SAT  = 64'h4000_0000_0000_0000;
  localparam logic [63:0]        BR_SAT    = 64'h0000_00FF_FFFF_FFFF;
  localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

  typedef struct packed {
    logic [FR_W-1:0]   frame_rate;
    logic [BR_W-1:0]   bit_rate;
    logic              bit_rate_ok;
    logic [HIST_W-1:0] fill;
  } rate_beat_t;

  logic                  clk_i;
  logic                  rst_ni    = 1'b0;
  logic                  s_tvalid  = 1'b0;
  logic [IN_W-1:0]       s_tdata   = '0;
  logic [0:0]            s_tuser   = '0;
  logic                  m_tready  = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [OUT_W-1:0]      m_axis_tdata_o;
  logic [0:0]            m_axis_tuser_o;
  logic                  cfg_ready_o;

  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic rx_hold      = 1'b0;
  int   rate_errors  = 0;

  // Expected rate beats in order; the sender advances due_wr, the checker due_rd.
  rate_beat_t due_ring[DUE_DEPTH];
  int         due_wr = 0;
  int         due_rd = 0;

  frame_and_bit_rate_meter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Register mirror and window state of the predictor.
  logic              counter_mode  = 1'b0;
  logic [HIST_W-1:0] history_len   = HIST_LEN_RST;
  logic [31:0]       max_gap_units = MAX_GAP_RST;
  logic [31:0]       tick_rate     = CNT_FREQ_RST;

  bit                 have_anchor = 1'b0;
  logic [63:0]        anchor_time = '0;
  logic [31:0]        gap_ring[RING_DEPTH];
  logic [63:0]        stamp_ring[RING_DEPTH];
  logic [BYTES_W-1:0] frame_size_ring[RING_DEPTH];
  int                 oldest      = 0;
  int                 fill_count  = 0;
  logic [63:0]        gap_total   = '0;
  logic [31:0]        byte_total  = '0;

  // Exact tick to 100 ns conversion; 2^36 whole seconds or more return the saturation value.
  function automatic logic [63:0] ticks_to_units(input logic [63:0] ticks);
    logic [63:0] whole, part, units;
    if (tick_rate == 0) return CONV_SAT;
    whole = ticks / 64'(tick_rate);
    part  = ticks % 64'(tick_rate);
    if (whole >= (64'd1 << 36)) return CONV_SAT;
    units = whole * UNITS + (part * UNITS) / 64'(tick_rate);
    return (units >= CONV_SAT) ? CONV_SAT : units;
  endfunction

  function automatic void clear_window();
    oldest     = 0;
    fill_count = 0;
    gap_total  = '0;
    byte_total = '0;
  endfunction

  // At most one entry leaves per push, so a lowered history length keeps the window size.
  function automatic void store_interval(input logic [63:0] stamp, input logic [31:0] gap,
                                         input logic [BYTES_W-1:0] bytes);
    int limit, slot;
    limit = (history_len > RING_DEPTH) ? RING_DEPTH : int'(history_len);
    if (fill_count == 0 && limit == 0) return;
    if (fill_count > 0 && fill_count + 1 > limit) begin
      gap_total  -= 64'(gap_ring[oldest]);
      byte_total -= 32'(frame_size_ring[oldest]);
      oldest      = (oldest + 1) % RING_DEPTH;
      fill_count--;
    end
    slot = (oldest + fill_count) % RING_DEPTH;
    gap_ring[slot]        = gap;
    stamp_ring[slot]      = stamp;
    frame_size_ring[slot] = bytes;
    gap_total  += 64'(gap);
    byte_total += 32'(bytes);
    fill_count++;
  endfunction

  function automatic bit predict_rate_beat(input logic [TIME_W-1:0] stamp,
                                           input logic [BYTES_W-1:0] bytes,
                                           input logic restart, output rate_beat_t beat);
    logic [63:0] t, interval, mean, span, kbits, rate;
    int          first, last;
    beat = '0;
    t    = 64'(stamp);
    if (restart) begin
      have_anchor = 1'b0;
      anchor_time = '0;
      clear_window();
      return 1'b0;
    end
    if (!have_anchor) begin
      have_anchor = 1'b1;
      anchor_time = t;
      clear_window();
      return 1'b0;
    end
    interval = '0;
    if (t > anchor_time) begin
      interval = counter_mode ? ticks_to_units(t - anchor_time) : t - anchor_time;
    end
    if (interval != 0 && interval < 64'(max_gap_units)) begin
      store_interval(t, interval[31:0], bytes);
    end else begin
      clear_window();
    end
    anchor_time = t;
    if (fill_count > 0) begin
      mean = gap_total / 64'(fill_count);
      if (mean != 0) beat.frame_rate = FR_W'(Q8_SCALE / mean);
      first = oldest;
      last  = (oldest + fill_count - 1) % RING_DEPTH;
      span  = '0;
      if (stamp_ring[last] > stamp_ring[first]) begin
        span = stamp_ring[last] - stamp_ring[first];
        if (counter_mode) span = ticks_to_units(span);
      end
      if (span != 0) begin
        kbits = 64'(byte_total / 32'(KB_DIVISOR)) * 64'd8;
        rate  = (kbits * Q8_SCALE) / span;
        if (rate > BR_SAT) rate = BR_SAT;
        beat.bit_rate    = rate[BR_W-1:0];
        beat.bit_rate_ok = 1'b1;
      end
    end
    beat.fill = HIST_W'(fill_count);
    return 1'b1;
  endfunction

  // All tasks below are entered right after a rising edge.
  task automatic send_frame(input logic [TIME_W-1:0] stamp, input logic [BYTES_W-1:0] bytes,
                            input logic restart);
    rate_beat_t beat;
    if (predict_rate_beat(stamp, bytes, restart, beat)) begin
      due_ring[due_wr % DUE_DEPTH] = beat;
      due_wr++;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({bytes, stamp});
    s_tuser  <= restart;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic wait_until_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (due_wr != due_rd);
    // Restart and first-frame beats give no rate beat, so allow a full event time as well.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TIMING_SOURCE:     counter_mode  = value[0];
      REG_HISTORY_LENGTH:    history_len   = value[HIST_W-1:0];
      REG_MAX_GAP:           max_gap_units = value;
      REG_COUNTER_FREQUENCY: tick_rate     = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic mode, input logic [HIST_W-1:0] hist,
                                input logic [31:0] gap, input logic [31:0] freq);
    wait_until_idle();
    write_reg(REG_TIMING_SOURCE, 32'(mode));
    write_reg(REG_HISTORY_LENGTH, 32'(hist));
    write_reg(REG_MAX_GAP, gap);
    write_reg(REG_COUNTER_FREQUENCY, freq);
  endtask

  function automatic logic [BYTES_W-1:0] pick_bytes();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return BYTES_W'($urandom_range(0, 250000));
    if (roll < 80) return BYTES_W'($urandom_range(0, 2000));
    if (roll < 92) return BYTES_W'($urandom);
    return $urandom_range(1) ? BYTES_MAX : '0;
  endfunction

  // Frame period in the current time base, chosen so that most intervals stay below max_gap.
  function automatic logic [63:0] pick_period();
    logic [63:0] lim, units, ticks;
    lim = (max_gap_units > 1) ? 64'(max_gap_units) - 1 : 64'd1;
    if (lim > 64'd2000000) lim = 64'd2000000;
    if ($urandom_range(3) == 0 && lim > 64) lim = 64;
    units = 64'($urandom_range(1, lim[31:0]));
    ticks = counter_mode ? (units * 64'(tick_rate)) / UNITS : units;
    return (ticks == 0) ? 64'd1 : ticks;
  endfunction

  // Mostly a steady frame stream with jitter; some restarts, broken timing and noise.
  task automatic run_traffic(input int count);
    logic [63:0] now, period, jitter, t;
    int          roll;
    roll = $urandom_range(2);
    if (roll == 0) now = 64'($urandom_range(0, 1000));
    else if (roll == 1) now = 64'(TIME_MAX) - 64'($urandom_range(0, 2000000000));
    else now = {$urandom, $urandom} >> 1;
    period = pick_period();
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 39) period = pick_period();
      roll = $urandom_range(99);
      if (roll < 3) begin
        send_frame(TIME_W'({$urandom, $urandom}), pick_bytes(), 1'b1);
      end else begin
        if (roll < 8) begin
          t = {$urandom, $urandom};
        end else if (roll < 12) begin
          case ($urandom_range(2))
            0: t = now;
            1: t = now - 64'($urandom_range(1, 1000000));
            default: t = now + ({$urandom, $urandom} >> $urandom_range(20, 40));
          endcase
        end else begin
          jitter = period >> 3;
          t = now + period - jitter + 64'($urandom_range(0, 32'(2 * jitter)));
        end
        now = {1'b0, t[TIME_W-1:0]};
        send_frame(now[TIME_W-1:0], pick_bytes(), 1'b0);
      end
    end
  endtask

  task automatic test_stream_edges();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_frame(TIME_W'({$urandom, $urandom}), BYTES_W'($urandom), 1'b1);
    send_frame('0, '0, 1'b0);
    send_frame(TIME_W'(100000), BYTES_MAX, 1'b0);
    send_frame(TIME_W'(200000), BYTES_W'(1000), 1'b0);
    send_frame(TIME_W'(200000), BYTES_W'(999), 1'b0);        // equal time
    send_frame(TIME_W'(150000), BYTES_W'(1), 1'b0);          // time going back
    send_frame(TIME_W'(50150000), BYTES_W'(12345), 1'b0);    // interval equal to max_gap
    send_frame(TIME_W'(100149999), BYTES_MAX, 1'b0);         // just below max_gap
    send_frame(TIME_W'(100150000), BYTES_MAX, 1'b0);         // tiny span saturates the bit rate
    send_frame(TIME_W'(0), BYTES_W'(0), 1'b1);
    send_frame(TIME_MAX - TIME_W'(1000), '0, 1'b0);
    send_frame(TIME_MAX, BYTES_MAX, 1'b0);
    send_frame(TIME_W'(5), BYTES_W'(77), 1'b0);
  endtask

  task automatic test_history_shrink();
    apply_settings(1'b0, HIST_LEN_RST, MAX_GAP_RST, CNT_FREQ_RST);
    send_frame(TIME_W'(7), BYTES_W'(3), 1'b1);
    send_frame(TIME_W'(1000), BYTES_W'(5000), 1'b0);
    send_frame(TIME_W'(2000), BYTES_W'(6000), 1'b0);
    send_frame(TIME_W'(3000), BYTES_W'(7000), 1'b0);
    send_frame(TIME_W'(4000), BYTES_W'(8000), 1'b0);
    wait_until_idle();
    write_reg(REG_HISTORY_LENGTH, 32'd1);
    send_frame(TIME_W'(5000), BYTES_W'(9000), 1'b0);
    send_frame(TIME_W'(6500), BYTES_W'(4000), 1'b0);
    wait_until_idle();
    write_reg(REG_HISTORY_LENGTH, 32'd0);
    send_frame(TIME_W'(7000), BYTES_W'(2500), 1'b0);
    send_frame(TIME_W'(9), BYTES_W'(1), 1'b1);
    send_frame(TIME_W'(8000), BYTES_W'(100), 1'b0);
    send_frame(TIME_W'(9000), BYTES_W'(100), 1'b0);          // zero history keeps nothing
  endtask

  // The receiver holds off while frames keep coming, so the meter must stall its input.
  task automatic test_backpressure();
    logic [63:0] now;
    apply_settings(1'b0, 7'd64, MAX_GAP_RST, CNT_FREQ_RST);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
    now = 64'($urandom_range(0, 100000));
    for (int i = 0; i < 30; i++) begin
      now = now + 64'($urandom_range(300000, 500000));
      send_frame(now[TIME_W-1:0], pick_bytes(), 1'b0);
    end
  endtask

  task automatic test_random_phases();
    logic              mode;
    logic [HIST_W-1:0] hist;
    logic [31:0]       gap, freq;
    int                count;
    for (int phase = 0; phase < 14; phase++) begin
      count = 160;
      freq  = CNT_FREQ_RST;
      case (phase)
        0:  begin mode = 1'b0; hist = 7'd32;  gap = MAX_GAP_RST; end
        1:  begin mode = 1'b0; hist = 7'd1;   gap = '1; end
        2:  begin mode = 1'b1; hist = 7'd64;  gap = MAX_GAP_RST; freq = 32'd27000000; end
        3:  begin mode = 1'b0; hist = 7'd0;   gap = 32'd1000000; count = 40; end
        4:  begin mode = 1'b1; hist = 7'd127; gap = '1; freq = '1; end
        5:  begin mode = 1'b0; hist = 7'd8;   gap = 32'd1; count = 40; end
        6:  begin mode = 1'b1; hist = 7'd16;  gap = MAX_GAP_RST; freq = 32'd1; end
        7:  begin mode = 1'b1; hist = 7'd4;   gap = MAX_GAP_RST; freq = '0; count = 40; end
        8:  begin mode = 1'b0; hist = 7'd64;  gap = '0; count = 40; end
        9:  begin mode = 1'b0; hist = 7'd3;   gap = $urandom_range(2, 4000000); end
        10: begin
          mode = 1'b1;
          hist = HIST_W'($urandom_range(1, 64));
          gap  = $urandom;
          freq = $urandom;
        end
        11: begin mode = 1'b1; hist = 7'd2;   gap = '1; freq = 32'd90000; end
        12: begin mode = 1'b0; hist = 7'd64;  gap = MAX_GAP_RST; end
        default: begin mode = 1'b1; hist = 7'd48; gap = 32'd20000000; end
      endcase
      apply_settings(mode, hist, gap, freq);
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 66; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 66; end
        default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
      endcase
      run_traffic(count);
    end
  endtask

  always @(posedge clk_i) begin
    m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin : check_rate_beats
    rate_beat_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got.frame_rate  = m_axis_tdata_o[FR_W-1:0];
      got.bit_rate    = m_axis_tdata_o[FR_W +: BR_W];
      got.fill        = m_axis_tdata_o[FR_W + BR_W +: HIST_W];
      got.bit_rate_ok = m_axis_tuser_o[0];
      if (due_wr == due_rd) begin
        $error("rate beat with none expected: frame_rate_q8 %0d", got.frame_rate);
        rate_errors++;
      end else begin
        want = due_ring[due_rd % DUE_DEPTH];
        due_rd++;
        if (got.frame_rate !== want.frame_rate) begin
          $error("frame_rate_q8 expected %0d actual %0d", want.frame_rate, got.frame_rate);
          rate_errors++;
        end
        if (got.bit_rate !== want.bit_rate) begin
          $error("bit_rate_q8 expected %0d actual %0d", want.bit_rate, got.bit_rate);
          rate_errors++;
        end
        if (got.bit_rate_ok !== want.bit_rate_ok) begin
          $error("bit_rate_valid expected %0d actual %0d", want.bit_rate_ok, got.bit_rate_ok);
          rate_errors++;
        end
        if (got.fill !== want.fill) begin
          $error("window_fill expected %0d actual %0d", want.fill, got.fill);
          rate_errors++;
        end
      end
    end
  end

  initial begin
    #100ms;
    $display("frame_and_bit_rate_meter verification failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_stream_edges();
    test_history_shrink();
    test_backpressure();
    test_random_phases();
    wait_until_idle();
    if (rate_errors == 0) begin
      $display("frame_and_bit_rate_meter verification clean");
    end else begin
      $display("frame_and_bit_rate_meter verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/fbrm_pkg.sv
src/fbrm_div.sv
src/frame_and_bit_rate_meter.sv
src/fbrm_checker.sv
sim/testbench.sv
